// ===== sv/lif_pkg.sv =====
// Shared types and constants of the leaky integrate-and-fire neuron array.
package lif_pkg;

  localparam int unsigned IdxW    = 3;
  localparam int unsigned IntenW  = 6;
  localparam int unsigned ThrW    = 16;
  localparam int unsigned LeakW   = 24;
  localparam int unsigned RefrW   = 24;
  localparam int unsigned PotW    = 33;
  localparam int unsigned TickW   = 48;
  localparam int unsigned CountW  = 32;
  localparam int unsigned TotalW  = 48;
  localparam int unsigned FracW   = 16;
  // Elapsed ticks are clamped here: any larger count drains every potential whose leak is not zero.
  localparam int unsigned IdleW   = PotW + 1;
  localparam int unsigned ProdW   = LeakW + IdleW;

  typedef enum logic {
    CMD_STIM = 1'b0,
    CMD_LOAD = 1'b1
  } lif_cmd_e;

  typedef struct packed {
    lif_cmd_e             cmd;
    logic [IdxW-1:0]      neuron_index;
    logic [IntenW-1:0]    intensity;
    logic [ThrW-1:0]      new_threshold;
    logic [LeakW-1:0]     new_leak;
  } lif_item_t;

endpackage

// ===== sv/lif_channels.sv =====
// Handshake channels of the neuron array: stimulus/load items, results, configuration.
interface lif_item_if;
  logic                          valid;
  logic                          ready;
  lif_pkg::lif_cmd_e             cmd;
  logic [lif_pkg::IdxW-1:0]      neuron_index;
  logic [lif_pkg::IntenW-1:0]    intensity;
  logic [lif_pkg::ThrW-1:0]      new_threshold;
  logic [lif_pkg::LeakW-1:0]     new_leak;

  modport source (output valid, cmd, neuron_index, intensity, new_threshold, new_leak,
                  input ready);
  modport sink (input valid, cmd, neuron_index, intensity, new_threshold, new_leak,
                output ready);
endinterface

interface lif_result_if;
  logic                          valid;
  logic                          ready;
  logic [lif_pkg::IdxW-1:0]      neuron_out;
  logic                          fired;
  logic                          gated;
  logic [lif_pkg::PotW-1:0]      potential_out;
  logic [lif_pkg::CountW-1:0]    neuron_spikes;
  logic [lif_pkg::TotalW-1:0]    spike_sum;

  modport source (output valid, neuron_out, fired, gated, potential_out, neuron_spikes,
                  spike_sum, input ready);
  modport sink (input valid, neuron_out, fired, gated, potential_out, neuron_spikes,
                spike_sum, output ready);
endinterface

interface lif_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lif_pkg::RefrW-1:0]     data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== sv/lif_neuron_array_step.sv =====
// Top level: event-driven array of leaky integrate-and-fire neurons.
//
// Channels: stim_i takes one beat per item. A load beat (cmd CMD_LOAD) writes
// the addressed neuron's integer threshold and Q8.16 per-tick leak. A stimulus
// beat (cmd CMD_STIM) advances the global tick, decays the neuron's Q17.16
// potential by leak times the ticks since its last update, and unless the
// neuron is refractory adds the intensity and fires it at threshold.
// Each item gives exactly one beat on res_o. cfg_i writes the refractory
// window in ticks; it is always ready, and the user must write it only while
// idle; the block does not enforce this. Throughput: one item per cycle unless
// res_o stalls. The input register, one pass of logic around the single
// leak-times-ticks multiplier, and the result register set that figure;
// the neuron state updates at the edge that loads the result, so the
// next item sees it at once.
// Reset clears every neuron's state, the tick, the counters and the window.
// When the receiver stalls, the result holds in its register, one more item
// waits in the input register, and stim_i ready drops until res_o moves.
module lif_neuron_array_step #(
  parameter int unsigned NEURONS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lif_item_if.sink      stim_i,
  lif_cfg_if.sink       cfg_i,
  lif_result_if.source  res_o
);

  localparam int unsigned SelW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int unsigned ExtW = (SelW > lif_pkg::IdxW) ? SelW : lif_pkg::IdxW;
  localparam logic [8:0]  NeuronsN = 9'(NEURONS);

  localparam int unsigned PotW   = lif_pkg::PotW;
  localparam int unsigned TickW  = lif_pkg::TickW;
  localparam int unsigned IdleW  = lif_pkg::IdleW;
  localparam int unsigned ProdW  = lif_pkg::ProdW;

  // Handshake and pipeline registers.
  logic                          in_valid_q;
  lif_pkg::lif_item_t            in_q;
  logic                          out_valid_q;
  logic [lif_pkg::IdxW-1:0]      out_idx_q;
  logic                          out_fired_q;
  logic                          out_gated_q;
  logic [PotW-1:0]               out_pot_q;
  logic [lif_pkg::CountW-1:0]    out_cnt_q;

  // Neuron state.
  logic [lif_pkg::RefrW-1:0]     refr_q;
  logic [TickW-1:0]              tick_q;
  logic [lif_pkg::TotalW-1:0]    total_q;
  logic [PotW-1:0]               pot_q       [NEURONS];
  logic [TickW-1:0]              last_upd_q  [NEURONS];
  logic [TickW-1:0]              last_fire_q [NEURONS];
  logic [lif_pkg::ThrW-1:0]      thr_q       [NEURONS];
  logic [lif_pkg::LeakW-1:0]     leak_q      [NEURONS];
  logic [lif_pkg::CountW-1:0]    cnt_q       [NEURONS];

  logic                          advance;
  logic                          stim_fire;

  // Datapath signals.
  logic                          is_stim;
  logic                          hit;
  logic [ExtW-1:0]               idx_ext;
  logic [SelW-1:0]               sel;
  logic [TickW-1:0]              tick_inc;
  logic [TickW-1:0]              tick_new;
  logic [PotW-1:0]               pot_rd;
  logic [lif_pkg::LeakW-1:0]     leak_rd;
  logic [lif_pkg::ThrW-1:0]      thr_rd;
  logic [lif_pkg::CountW-1:0]    cnt_rd;
  logic [TickW-1:0]              idle;
  logic [IdleW-1:0]              idle_c;
  logic [ProdW-1:0]              decay_prod;
  logic [PotW-1:0]               pot_dec;
  logic [TickW-1:0]              since_fire;
  logic                          refractory;
  logic [PotW:0]                 pot_sum;
  logic [PotW-1:0]               pot_sat;
  logic                          reach;
  logic [PotW-1:0]               pot_new;
  logic [lif_pkg::CountW-1:0]    cnt_new;
  logic [lif_pkg::TotalW-1:0]    total_new;

  // Advance the stage when the result register is free or being drained.
  assign advance      = in_valid_q && (!out_valid_q || res_o.ready);
  assign stim_i.ready = !in_valid_q || advance;
  assign cfg_i.ready  = 1'b1;

  always_comb begin
    is_stim  = (in_q.cmd == lif_pkg::CMD_STIM);
    idx_ext  = ExtW'(in_q.neuron_index);
    hit      = {6'd0, in_q.neuron_index} < NeuronsN;
    sel      = hit ? idx_ext[SelW-1:0] : '0;

    tick_inc = (tick_q != '1) ? tick_q + TickW'(1) : tick_q;
    tick_new = is_stim ? tick_inc : tick_q;

    pot_rd   = pot_q[sel];
    leak_rd  = leak_q[sel];
    thr_rd   = thr_q[sel];
    cnt_rd   = cnt_q[sel];

    // Decay: drain to zero once leak times idle ticks passes the potential.
    idle       = tick_new - last_upd_q[sel];
    idle_c     = (|idle[TickW-1:PotW]) ? {1'b1, {PotW{1'b0}}} : {1'b0, idle[PotW-1:0]};
    decay_prod = ProdW'(leak_rd) * ProdW'(idle_c);
    pot_dec    = (decay_prod > ProdW'(pot_rd)) ? '0 : pot_rd - decay_prod[PotW-1:0];

    since_fire = tick_new - last_fire_q[sel];
    refractory = since_fire < TickW'(refr_q);

    // Integrate with saturation, then check the threshold.
    pot_sum  = {1'b0, pot_dec} + (PotW+1)'({in_q.intensity, {lif_pkg::FracW{1'b0}}});
    pot_sat  = pot_sum[PotW] ? '1 : pot_sum[PotW-1:0];
    reach    = pot_sat >= PotW'({thr_rd, {lif_pkg::FracW{1'b0}}});

    stim_fire = hit && is_stim && !refractory && reach;

    if (!is_stim) begin
      pot_new = pot_rd;
    end else if (refractory) begin
      pot_new = pot_dec;
    end else if (reach) begin
      pot_new = '0;
    end else begin
      pot_new = pot_sat;
    end

    cnt_new   = (stim_fire && cnt_rd != '1) ? cnt_rd + lif_pkg::CountW'(1) : cnt_rd;
    total_new = (stim_fire && total_q != '1) ? total_q + lif_pkg::TotalW'(1) : total_q;
  end

  // Handshake control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (stim_i.valid && stim_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input and result payload.
  always_ff @(posedge clk_i) begin
    if (stim_i.valid && stim_i.ready) begin
      in_q.cmd           <= stim_i.cmd;
      in_q.neuron_index  <= stim_i.neuron_index;
      in_q.intensity     <= stim_i.intensity;
      in_q.new_threshold <= stim_i.new_threshold;
      in_q.new_leak      <= stim_i.new_leak;
    end
    if (advance) begin
      out_idx_q   <= in_q.neuron_index;
      out_fired_q <= stim_fire;
      out_gated_q <= hit && is_stim && refractory;
      out_pot_q   <= hit ? pot_new : '0;
      out_cnt_q   <= hit ? cnt_new : '0;
    end
  end

  // Neuron state: commit at the edge that loads the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refr_q  <= '0;
      tick_q  <= '0;
      total_q <= '0;
      for (int i = 0; i < NEURONS; i++) begin
        pot_q[i]       <= '0;
        last_upd_q[i]  <= '0;
        last_fire_q[i] <= '0;
        thr_q[i]       <= '0;
        leak_q[i]      <= '0;
        cnt_q[i]       <= '0;
      end
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        refr_q <= cfg_i.data;
      end
      if (advance) begin
        tick_q  <= tick_new;
        total_q <= total_new;
        if (hit) begin
          if (is_stim) begin
            pot_q[sel]      <= pot_new;
            last_upd_q[sel] <= tick_new;
            cnt_q[sel]      <= cnt_new;
            if (stim_fire) begin
              last_fire_q[sel] <= tick_new;
            end
          end else begin
            thr_q[sel]  <= in_q.new_threshold;
            leak_q[sel] <= in_q.new_leak;
          end
        end
      end
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.neuron_out    = out_idx_q;
  assign res_o.fired         = out_fired_q;
  assign res_o.gated         = out_gated_q;
  assign res_o.potential_out = out_pot_q;
  assign res_o.neuron_spikes = out_cnt_q;
  assign res_o.spike_sum     = total_q;

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the leaky integrate-and-fire neuron array step block.
module tb;

  localparam int unsigned NEURONS     = 8;
  localparam int unsigned CYCLE_LIMIT = 300000;
  // Spare cycles waited after the last owed result has come back, to cover any slack.
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned PHASES      = 6;

  // One result beat as the block reports it.
  typedef struct packed {
    logic [lif_pkg::IdxW-1:0]   neuron_out;
    logic                       fired;
    logic                       gated;
    logic [lif_pkg::PotW-1:0]   potential_out;
    logic [lif_pkg::CountW-1:0] neuron_spikes;
    logic [lif_pkg::TotalW-1:0] spike_sum;
  } spike_report_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_WINDOW
  } row_kind_e;

  // Directed row: either one item beat or one refractory window write.
  typedef struct {
    row_kind_e                 kind;
    lif_pkg::lif_item_t        item;
    logic [lif_pkg::RefrW-1:0] window;
    bit                        typed;
    spike_report_t             want;
  } plan_row_t;

  localparam spike_report_t NO_WANT = '0;

  logic clk = 1'b0;
  logic rst_n;

  lif_item_if   stim_if ();
  lif_cfg_if    cfg_if ();
  lif_result_if res_if ();

  lif_neuron_array_step #(
    .NEURONS(NEURONS)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .stim_i(stim_if),
    .cfg_i (cfg_if),
    .res_o (res_if)
  );

  always #4 clk = ~clk;

  // Neuron state as the bench sees it, advanced once per accepted item beat.
  logic [lif_pkg::TickW-1:0]  tick_cnt;
  logic [lif_pkg::TotalW-1:0] total_spk;
  logic [lif_pkg::RefrW-1:0]  window_q;
  logic [lif_pkg::PotW-1:0]   pot_mem      [NEURONS];
  logic [lif_pkg::TickW-1:0]  upd_tick_mem [NEURONS];
  logic [lif_pkg::TickW-1:0]  fire_tick_mem[NEURONS];
  logic [lif_pkg::ThrW-1:0]   thr_mem      [NEURONS];
  logic [lif_pkg::LeakW-1:0]  leak_mem     [NEURONS];
  logic [lif_pkg::CountW-1:0] spike_mem    [NEURONS];

  spike_report_t reports_due[$];
  int unsigned   mismatches = 0;
  int unsigned   send_gap_pct = 0;
  int unsigned   stall_pct = 0;
  int unsigned   cycle_count = 0;

  // Apply one item to the bench's neuron state and return the report it causes.
  function automatic spike_report_t integrate_and_fire(input lif_pkg::lif_item_t it);
    logic [lif_pkg::IdxW-1:0]                 n;
    logic [lif_pkg::TickW-1:0]                elapsed;
    logic [lif_pkg::LeakW+lif_pkg::TickW-1:0] drain;
    logic [lif_pkg::PotW:0]                   boost;
    logic [lif_pkg::PotW:0]                   sum;
    logic [lif_pkg::PotW-1:0]                 thr_scaled;
    logic [lif_pkg::PotW-1:0]                 pot;
    spike_report_t                            r;
    n = it.neuron_index;
    r = '0;
    r.neuron_out = n;
    if (it.cmd == lif_pkg::CMD_LOAD) begin
      thr_mem[n]  = it.new_threshold;
      leak_mem[n] = it.new_leak;
    end else begin
      if (tick_cnt != {lif_pkg::TickW{1'b1}}) tick_cnt++;
      // Leak over the idle ticks; anything that drains past zero clamps there.
      elapsed = tick_cnt - upd_tick_mem[n];
      drain = leak_mem[n] * elapsed;
      pot = pot_mem[n];
      if (drain > pot) pot = '0;
      else pot = pot - drain[lif_pkg::PotW-1:0];
      upd_tick_mem[n] = tick_cnt;
      if ((tick_cnt - fire_tick_mem[n]) < window_q) begin
        r.gated = 1'b1;
      end else begin
        boost = '0;
        boost[lif_pkg::FracW +: lif_pkg::IntenW] = it.intensity;
        sum = pot + boost;
        if (sum > {1'b0, {lif_pkg::PotW{1'b1}}}) pot = '1;
        else pot = sum[lif_pkg::PotW-1:0];
        thr_scaled = '0;
        thr_scaled[lif_pkg::FracW +: lif_pkg::ThrW] = thr_mem[n];
        if (pot >= thr_scaled) begin
          pot = '0;
          r.fired = 1'b1;
          fire_tick_mem[n] = tick_cnt;
          if (spike_mem[n] != {lif_pkg::CountW{1'b1}}) spike_mem[n]++;
          if (total_spk != {lif_pkg::TotalW{1'b1}}) total_spk++;
        end
      end
      pot_mem[n] = pot;
    end
    r.potential_out = pot_mem[n];
    r.neuron_spikes = spike_mem[n];
    r.spike_sum     = total_spk;
    return r;
  endfunction

  function automatic plan_row_t item_row(input lif_pkg::lif_cmd_e cmd, input int unsigned idx,
                                         input int unsigned inten, input int unsigned thr,
                                         input int unsigned leak, input bit typed,
                                         input spike_report_t want);
    plan_row_t row;
    row.kind               = ROW_ITEM;
    row.item.cmd           = cmd;
    row.item.neuron_index  = lif_pkg::IdxW'(idx);
    row.item.intensity     = lif_pkg::IntenW'(inten);
    row.item.new_threshold = lif_pkg::ThrW'(thr);
    row.item.new_leak      = lif_pkg::LeakW'(leak);
    row.window             = '0;
    row.typed              = typed;
    row.want               = want;
    return row;
  endfunction

  function automatic plan_row_t window_row(input logic [lif_pkg::RefrW-1:0] value);
    plan_row_t row;
    row.kind   = ROW_WINDOW;
    row.item   = '0;
    row.window = value;
    row.typed  = 1'b0;
    row.want   = NO_WANT;
    return row;
  endfunction

  // Mostly stimuli to random neurons with random content; loads now and then
  // retune a neuron, usually to a small threshold and a gentle leak so that
  // spikes actually happen. Unused fields carry noise.
  function automatic lif_pkg::lif_item_t random_item();
    lif_pkg::lif_item_t it;
    int unsigned        pick;
    it.cmd           = lif_pkg::CMD_STIM;
    it.neuron_index  = lif_pkg::IdxW'($urandom_range(NEURONS - 1));
    it.intensity     = lif_pkg::IntenW'($urandom_range(63));
    it.new_threshold = lif_pkg::ThrW'($urandom);
    it.new_leak      = lif_pkg::LeakW'($urandom);
    if ($urandom_range(99) < 12) begin
      it.cmd = lif_pkg::CMD_LOAD;
      pick = $urandom_range(99);
      if (pick < 15) it.new_threshold = '0;
      else if (pick < 85) it.new_threshold = lif_pkg::ThrW'($urandom_range(1, 400));
      pick = $urandom_range(99);
      if (pick < 30) it.new_leak = '0;
      else if (pick < 85) it.new_leak = lif_pkg::LeakW'($urandom_range(1, 24'h020000));
    end
    return it;
  endfunction

  function automatic void note_field(input string name, input logic [63:0] want,
                                     input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Present one item beat, with a random gap ahead of it, and hold it until
  // the block takes it. Queue the report it owes at the accepting edge.
  task automatic drive_item(input lif_pkg::lif_item_t it, input bit typed,
                            input spike_report_t want);
    spike_report_t predicted;
    while ($urandom_range(99) < send_gap_pct) begin
      stim_if.valid <= 1'b0;
      @(posedge clk);
    end
    stim_if.valid         <= 1'b1;
    stim_if.cmd           <= it.cmd;
    stim_if.neuron_index  <= it.neuron_index;
    stim_if.intensity     <= it.intensity;
    stim_if.new_threshold <= it.new_threshold;
    stim_if.new_leak      <= it.new_leak;
    do @(posedge clk); while (!stim_if.ready);
    predicted = integrate_and_fire(it);
    reports_due.push_back(typed ? want : predicted);
  endtask

  // Drop valid and wait until every owed report has come back, plus the tail.
  task automatic settle();
    stim_if.valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Write the refractory window only once the block has gone quiet.
  task automatic write_window(input logic [lif_pkg::RefrW-1:0] value);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    window_q = value;
  endtask

  // Result side: check each beat against the oldest owed report, then pick
  // the next cycle's ready at the current stall rate.
  always @(posedge clk) begin : rx_check
    spike_report_t got;
    spike_report_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      got.neuron_out    = res_if.neuron_out;
      got.fired         = res_if.fired;
      got.gated         = res_if.gated;
      got.potential_out = res_if.potential_out;
      got.neuron_spikes = res_if.neuron_spikes;
      got.spike_sum     = res_if.spike_sum;
      if (reports_due.size() == 0) begin
        $display("%0t: result beat with nothing owed, actual %h", $time, got);
        mismatches++;
      end else begin
        want = reports_due.pop_front();
        note_field("neuron_out", want.neuron_out, got.neuron_out);
        note_field("fired", want.fired, got.fired);
        note_field("gated", want.gated, got.gated);
        note_field("potential_out", want.potential_out, got.potential_out);
        note_field("neuron_spikes", want.neuron_spikes, got.neuron_spikes);
        note_field("spike_sum", want.spike_sum, got.spike_sum);
      end
    end
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("[lif_neuron_array_step] ERROR");
    $finish;
  end

  initial begin
    plan_row_t                 plan[$];
    logic [lif_pkg::RefrW-1:0] phase_window[PHASES];

    // Hold every input at a known value through reset.
    rst_n                 = 1'b0;
    stim_if.valid         = 1'b0;
    stim_if.cmd           = lif_pkg::CMD_STIM;
    stim_if.neuron_index  = '0;
    stim_if.intensity     = '0;
    stim_if.new_threshold = '0;
    stim_if.new_leak      = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.data           = '0;
    res_if.ready          = 1'b0;

    tick_cnt  = '0;
    total_spk = '0;
    window_q  = '0;
    for (int i = 0; i < NEURONS; i++) begin
      pot_mem[i]       = '0;
      upd_tick_mem[i]  = '0;
      fire_tick_mem[i] = '0;
      thr_mem[i]       = '0;
      leak_mem[i]      = '0;
      spike_mem[i]     = '0;
    end

    // Directed part. Early stimuli first: with a window of 4 and every
    // neuron's last fire stamped at tick zero, ticks 1 to 3 are gated and
    // tick 4 is the first to integrate; a zero threshold then fires at once.
    plan.push_back(window_row(24'd4));
    plan.push_back(item_row(lif_pkg::CMD_STIM, 0, 63, 0, 0, 1'b1,
                            '{3'd0, 1'b0, 1'b1, 33'd0, 32'd0, 48'd0}));
    plan.push_back(item_row(lif_pkg::CMD_STIM, 3, 10, 0, 0, 1'b1,
                            '{3'd3, 1'b0, 1'b1, 33'd0, 32'd0, 48'd0}));
    plan.push_back(item_row(lif_pkg::CMD_STIM, 0, 0, 0, 0, 1'b0, NO_WANT));
    plan.push_back(item_row(lif_pkg::CMD_STIM, 0, 5, 0, 0, 1'b1,
                            '{3'd0, 1'b1, 1'b0, 33'd0, 32'd1, 48'd1}));
    plan.push_back(item_row(lif_pkg::CMD_STIM, 0, 5, 0, 0, 1'b0, NO_WANT));
    plan.push_back(window_row(24'd0));
    // Extremes: top threshold and top leak. The load shows the neuron
    // unchanged; each stimulus drains the old potential to zero and then
    // adds the full intensity, never reaching threshold.
    plan.push_back(item_row(lif_pkg::CMD_LOAD, 7, 0, 16'hFFFF, 24'hFFFFFF, 1'b1,
                            '{3'd7, 1'b0, 1'b0, 33'd0, 32'd0, 48'd1}));
    plan.push_back(item_row(lif_pkg::CMD_STIM, 7, 63, 0, 0, 1'b1,
                            '{3'd7, 1'b0, 1'b0, 33'h0_003F_0000, 32'd0, 48'd1}));
    plan.push_back(item_row(lif_pkg::CMD_STIM, 7, 63, 0, 0, 1'b1,
                            '{3'd7, 1'b0, 1'b0, 33'h0_003F_0000, 32'd0, 48'd1}));
    // Gentle leak of one unit per tick: integrate, leak, then cross threshold.
    plan.push_back(item_row(lif_pkg::CMD_LOAD, 1, 0, 100, 24'h010000, 1'b0, NO_WANT));
    plan.push_back(item_row(lif_pkg::CMD_STIM, 1, 63, 0, 0, 1'b0, NO_WANT));
    plan.push_back(item_row(lif_pkg::CMD_STIM, 1, 40, 0, 0, 1'b0, NO_WANT));
    plan.push_back(item_row(lif_pkg::CMD_STIM, 1, 0, 0, 0, 1'b0, NO_WANT));
    plan.push_back(item_row(lif_pkg::CMD_LOAD, 2, 0, 1, 0, 1'b0, NO_WANT));
    plan.push_back(item_row(lif_pkg::CMD_STIM, 2, 1, 0, 0, 1'b0, NO_WANT));
    plan.push_back(item_row(lif_pkg::CMD_STIM, 2, 0, 0, 0, 1'b0, NO_WANT));
    plan.push_back(item_row(lif_pkg::CMD_LOAD, 4, 0, 16'hAAAA, 24'h555555, 1'b0, NO_WANT));
    plan.push_back(item_row(lif_pkg::CMD_STIM, 4, 6'h2A, 0, 0, 1'b0, NO_WANT));
    plan.push_back(item_row(lif_pkg::CMD_LOAD, 6, 0, 16'h5555, 24'hAAAAAA, 1'b0, NO_WANT));
    plan.push_back(item_row(lif_pkg::CMD_STIM, 6, 6'h15, 0, 0, 1'b0, NO_WANT));
    // Widest window: every neuron stays refractory.
    plan.push_back(window_row(24'hFFFFFF));
    plan.push_back(item_row(lif_pkg::CMD_STIM, 2, 63, 0, 0, 1'b0, NO_WANT));
    plan.push_back(item_row(lif_pkg::CMD_STIM, 5, 63, 0, 0, 1'b0, NO_WANT));
    plan.push_back(window_row(24'd0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_WINDOW) begin
        write_window(plan[r].window);
      end else begin
        drive_item(plan[r].item, plan[r].typed, plan[r].want);
      end
    end

    // Random part: one window per phase, rotating through the idling mixes
    // (none, sender gaps, receiver stalls, both lightly).
    phase_window[0] = 24'd3;
    phase_window[1] = 24'd0;
    phase_window[2] = 24'hFFFFFF;
    phase_window[3] = lif_pkg::RefrW'($urandom_range(1, 16));
    phase_window[4] = 24'd12;
    phase_window[5] = 24'd1;
    for (int ph = 0; ph < PHASES; ph++) begin
      write_window(phase_window[ph]);
      case (ph % 4)
        0: begin
          send_gap_pct = 0;
          stall_pct    = 0;
        end
        1: begin
          send_gap_pct = 79;
          stall_pct    = 0;
        end
        2: begin
          send_gap_pct = 0;
          stall_pct    = 79;
        end
        default: begin
          send_gap_pct = 16;
          stall_pct    = 16;
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) drive_item(random_item(), 1'b0, NO_WANT);
    end

    settle();
    if (mismatches == 0) begin
      $display("[lif_neuron_array_step] OK");
    end else begin
      $display("[lif_neuron_array_step] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lif_pkg.sv
sv/lif_channels.sv
sv/lif_neuron_array_step.sv
bench/tb.sv
